[design/kst_pkg.sv]
// ---------------------------------------------------------------------------
// kst_pkg
// Shared constants, operation codes and control types for the keyed signal
// table.
// ---------------------------------------------------------------------------
package kst_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam int KIND_W  = 2;
  localparam int KEY_W   = 16;
  localparam int WORD_W  = 32;
  localparam int TYPE_W  = 8;
  localparam int STAMP_W = 32;

  localparam logic [KIND_W-1:0] OP_DEFINE = 2'd0;
  localparam logic [KIND_W-1:0] OP_SET    = 2'd1;
  localparam logic [KIND_W-1:0] OP_GET    = 2'd2;
  localparam logic [KIND_W-1:0] OP_REMOVE = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the request fields
    logic exec;   // apply the operation and load the result register
  } kst_cmd_t;

endpackage

[design/kst_if.sv]
// ---------------------------------------------------------------------------
// kst_if
// Request and response channels of the keyed signal table, each a
// valid/ready handshake with its payload.
// ---------------------------------------------------------------------------
interface kst_req_if;
  logic                        valid;
  logic                        ready;
  logic [kst_pkg::KIND_W-1:0]  kind;
  logic [kst_pkg::KEY_W-1:0]   signal_id;
  logic [kst_pkg::WORD_W-1:0]  data_word;
  logic [kst_pkg::TYPE_W-1:0]  signal_type;
  logic [kst_pkg::STAMP_W-1:0] now_ms;

  modport source (output valid, kind, signal_id, data_word, signal_type, now_ms,
                  input ready);
  modport sink (input valid, kind, signal_id, data_word, signal_type, now_ms,
                output ready);
endinterface

interface kst_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [kst_pkg::WORD_W-1:0]  value_out;
  logic [kst_pkg::STAMP_W-1:0] stamp_out;
  logic [kst_pkg::TYPE_W-1:0]  type_out;

  modport source (output valid, ok, value_out, stamp_out, type_out, input ready);
  modport sink (input valid, ok, value_out, stamp_out, type_out, output ready);
endinterface

[design/keyed_signal_table.sv]
// ---------------------------------------------------------------------------
// keyed_signal_table
// Associative table of signal entries keyed by a 16-bit id.
// ---------------------------------------------------------------------------
// Usage: each transfer on the req channel carries one operation (define,
// set, get or remove) with its id and data; exactly one transfer follows
// on the rsp channel with the ok flag and, for a get that hits, the stored
// value, timestamp and type code (zero otherwise).
// A request accepted at one edge is executed in the next cycle and its
// response is valid from the cycle after.
// The table takes one request at a time: the cycle after capture does
// the parallel compare of all keys against the id, picks the matching
// entry (or, for a define without a match, the lowest free one) and
// applies the operation. A new request is accepted in the cycle in which
// the pending response transfers.
// Stall: while rsp is not taken the result holds and req is not ready.
// Reset (synchronous, rst high) clears all entry valid bits and the
// controller; the table is empty and ready for a request straight away.
// ---------------------------------------------------------------------------
module keyed_signal_table (
  input  logic   clk,
  input  logic   rst,
  kst_req_if.sink   req,
  kst_rsp_if.source rsp
);

  kst_pkg::kst_cmd_t cmd;

  kst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  kst_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .kind        (req.kind),
    .signal_id   (req.signal_id),
    .data_word   (req.data_word),
    .signal_type (req.signal_type),
    .now_ms      (req.now_ms),
    .ok          (rsp.ok),
    .value_out   (rsp.value_out),
    .stamp_out   (rsp.stamp_out),
    .type_out    (rsp.type_out)
  );

endmodule

[design/kst_ctrl.sv]
// ---------------------------------------------------------------------------
// kst_ctrl
// Controller: sequences capture, execution and response hand-off.
// ---------------------------------------------------------------------------
module kst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output kst_pkg::kst_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       req_xfer;

  // A new request may be taken in the same cycle as the held response leaves.
  assign req_ready = (state == ST_IDLE) || ((state == ST_HOLD) && rsp_ready);
  assign req_xfer  = req_valid && req_ready;
  assign rsp_valid = (state == ST_HOLD);

  assign cmd.load = req_xfer;
  assign cmd.exec = (state == ST_EXEC);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_xfer) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (req_xfer)      state_next = ST_EXEC;
        else if (rsp_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

[design/kst_datapath.sv]
// ---------------------------------------------------------------------------
// kst_datapath
// Entry storage, parallel key match, free-slot search and result register.
// ---------------------------------------------------------------------------
module kst_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  kst_pkg::kst_cmd_t           cmd,
  input  logic [kst_pkg::KIND_W-1:0]  kind,
  input  logic [kst_pkg::KEY_W-1:0]   signal_id,
  input  logic [kst_pkg::WORD_W-1:0]  data_word,
  input  logic [kst_pkg::TYPE_W-1:0]  signal_type,
  input  logic [kst_pkg::STAMP_W-1:0] now_ms,
  output logic                        ok,
  output logic [kst_pkg::WORD_W-1:0]  value_out,
  output logic [kst_pkg::STAMP_W-1:0] stamp_out,
  output logic [kst_pkg::TYPE_W-1:0]  type_out
);

  // Captured request.
  logic [kst_pkg::KIND_W-1:0]  kind_q;
  logic [kst_pkg::KEY_W-1:0]   key_q;
  logic [kst_pkg::WORD_W-1:0]  word_q;
  logic [kst_pkg::TYPE_W-1:0]  type_q;
  logic [kst_pkg::STAMP_W-1:0] now_q;

  // Table.
  logic [kst_pkg::CAPACITY-1:0] entry_valid;
  logic [kst_pkg::KEY_W-1:0]    entry_key   [kst_pkg::CAPACITY];
  logic [kst_pkg::TYPE_W-1:0]   entry_type  [kst_pkg::CAPACITY];
  logic [kst_pkg::WORD_W-1:0]   entry_value [kst_pkg::CAPACITY];
  logic [kst_pkg::STAMP_W-1:0]  entry_stamp [kst_pkg::CAPACITY];

  logic [kst_pkg::CAPACITY-1:0] hit_vec;
  logic                         hit;
  logic [kst_pkg::IDX_W-1:0]    hit_idx;
  logic                         free_any;
  logic [kst_pkg::IDX_W-1:0]    free_idx;
  logic                         define_ok;
  logic [kst_pkg::IDX_W-1:0]    def_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      key_q  <= signal_id;
      word_q <= data_word;
      type_q <= signal_type;
      now_q  <= now_ms;
    end
  end

  // Ids are unique, so at most one entry matches and the index can be
  // formed by OR-ing the indices of matching entries.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < kst_pkg::CAPACITY; i++) begin
      hit_vec[i] = entry_valid[i] && (entry_key[i] == key_q);
      if (hit_vec[i]) hit_idx = hit_idx | kst_pkg::IDX_W'(i);
    end
    hit = |hit_vec;
  end

  // Lowest free slot: scan downwards so the lowest clear bit wins.
  always_comb begin
    free_idx = '0;
    for (int i = kst_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (!entry_valid[i]) free_idx = kst_pkg::IDX_W'(i);
    end
    free_any = ~&entry_valid;
  end

  assign define_ok = hit || free_any;
  assign def_idx   = hit ? hit_idx : free_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.exec) begin
      case (kind_q)
        kst_pkg::OP_DEFINE: begin
          if (define_ok) entry_valid[def_idx] <= 1'b1;
        end
        kst_pkg::OP_REMOVE: begin
          if (hit) entry_valid[hit_idx] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      case (kind_q)
        kst_pkg::OP_DEFINE: begin
          if (define_ok) begin
            entry_key[def_idx]   <= key_q;
            entry_type[def_idx]  <= type_q;
            entry_value[def_idx] <= word_q;
            entry_stamp[def_idx] <= '0;
          end
        end
        kst_pkg::OP_SET: begin
          if (hit) begin
            entry_value[hit_idx] <= word_q;
            entry_stamp[hit_idx] <= now_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register; it holds while the response waits for its transfer.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      value_out <= '0;
      stamp_out <= '0;
      type_out  <= '0;
      case (kind_q)
        kst_pkg::OP_DEFINE: begin
          ok <= define_ok;
        end
        kst_pkg::OP_GET: begin
          ok <= hit;
          if (hit) begin
            value_out <= entry_value[hit_idx];
            stamp_out <= entry_stamp[hit_idx];
            type_out  <= entry_type[hit_idx];
          end
        end
        default: begin
          ok <= hit;
        end
      endcase
    end
  end

endmodule
